// File: rtl/kfvs_pkg.sv
`default_nettype none
package kfvs_pkg;

    localparam int MAX_KEYS   = 64;
    localparam int KEY_W      = 6;
    localparam int CNT_W      = 7;
    localparam int FRAC_BITS  = 16;
    localparam int DATA_W     = 32;
    localparam int CDEPTH     = 3 * MAX_KEYS;
    localparam int CADDR_W    = 8;
    localparam int DIV_W      = DATA_W + 2;
    localparam int MOP_W      = 36;
    localparam int PROD_W     = 2 * MOP_W;
    localparam int ACC_W      = PROD_W - FRAC_BITS + 2;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 7;

    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    localparam logic [1:0] SLOT_IN  = 2'd0;
    localparam logic [1:0] SLOT_VAL = 2'd1;
    localparam logic [1:0] SLOT_OUT = 2'd2;

    localparam logic [1:0] MODE_STEP   = 2'd0;
    localparam logic [1:0] MODE_LINEAR = 2'd1;
    localparam logic [1:0] MODE_CUBIC  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_INTERP_MODE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_COUNT   = 1'd1;

    // key time read address source
    localparam logic [1:0] TA_FIRST = 2'd0;
    localparam logic [1:0] TA_LAST  = 2'd1;
    localparam logic [1:0] TA_SCAN  = 2'd2;
    localparam logic [1:0] TA_PREV  = 2'd3;

    // component read key source
    localparam logic [1:0] CK_FIRST = 2'd0;
    localparam logic [1:0] CK_LAST  = 2'd1;
    localparam logic [1:0] CK_A     = 2'd2;
    localparam logic [1:0] CK_B     = 2'd3;

    localparam logic [1:0] CAP_P0 = 2'd0;
    localparam logic [1:0] CAP_M0 = 2'd1;
    localparam logic [1:0] CAP_P1 = 2'd2;
    localparam logic [1:0] CAP_M1 = 2'd3;

    localparam logic [3:0] MO_UU    = 4'd0;
    localparam logic [3:0] MO_U2U   = 4'd1;
    localparam logic [3:0] MO_H10DT = 4'd2;
    localparam logic [3:0] MO_H11DT = 4'd3;
    localparam logic [3:0] MO_LIN   = 4'd4;
    localparam logic [3:0] MO_H00P0 = 4'd5;
    localparam logic [3:0] MO_S10M0 = 4'd6;
    localparam logic [3:0] MO_H01P1 = 4'd7;
    localparam logic [3:0] MO_S11M1 = 4'd8;

    localparam logic [1:0] RS_EMPTY = 2'd0;
    localparam logic [1:0] RS_VALUE = 2'd1;
    localparam logic [1:0] RS_ACC   = 2'd2;
    localparam logic [1:0] RS_ZERO  = 2'd3;

    typedef struct packed {
        logic                     op;
        logic [KEY_W-1:0]         key_index;
        logic [1:0]               slot;
        logic signed [DATA_W-1:0] time_value;
        logic signed [DATA_W-1:0] vec_x;
        logic signed [DATA_W-1:0] vec_y;
        logic signed [DATA_W-1:0] vec_z;
    } t_in;

    typedef struct packed {
        logic signed [DATA_W-1:0] out_x;
        logic signed [DATA_W-1:0] out_y;
        logic signed [DATA_W-1:0] out_z;
        logic                     was_empty;
    } t_out;

    typedef struct packed {
        logic       load_we;
        logic       sample_start;
        logic [1:0] taddr_sel;
        logic       idx_init;
        logic       idx_inc;
        logic       latch_b;
        logic       dt_load;
        logic       div_step;
        logic [1:0] ckey;
        logic [1:0] cslot;
        logic       cap_en;
        logic [1:0] cap_sel;
        logic       acc_init;
        logic       acc_lin;
        logic       mul_issue;
        logic       mul_cap;
        logic [3:0] mop;
        logic [1:0] comp;
        logic       res_load;
        logic [1:0] res_sel;
    } t_cmd;

    typedef struct packed {
        logic       n_zero;
        logic [1:0] mode;
        logic       q_le_t;
        logic       q_ge_t;
        logic       t_gt_q;
        logic       cidx_last;
    } t_stat;

endpackage
`default_nettype wire

// File: rtl/kfvs_ram.sv
`default_nettype none
module kfvs_ram #(
    parameter int W = 32,
    parameter int D = 64
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_we,
    input  wire logic [$clog2(D)-1:0] i_waddr,
    input  wire logic [W-1:0]         i_wdata,
    input  wire logic [$clog2(D)-1:0] i_raddr,
    output logic      [W-1:0]         o_rdata
);

    logic [W-1:0] mem [D];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end

endmodule
`default_nettype wire

// File: rtl/kfvs_datapath.sv
`default_nettype none
module kfvs_datapath
    import kfvs_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire t_cmd                  i_cmd,
    output t_stat                      o_stat,
    input  wire t_in                   i_in,
    input  wire logic                  i_cfg_valid,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_out                       o_out
);

    localparam logic signed [ACC_W-1:0] SAT_MAX =
        {{(ACC_W-DATA_W+1){1'b0}}, {(DATA_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] SAT_MIN =
        {{(ACC_W-DATA_W+1){1'b1}}, {(DATA_W-1){1'b0}}};
    localparam logic signed [MOP_W-1:0] ONE = MOP_W'(1) <<< FRAC_BITS;

    function automatic logic [CADDR_W-1:0] comp_addr(input logic [KEY_W-1:0] k,
                                                     input logic [1:0] s);
        logic [CADDR_W-1:0] kk;
        kk = CADDR_W'(k);
        return (kk << 1) + kk + CADDR_W'(s);
    endfunction

    function automatic logic signed [MOP_W-1:0] sx(input logic [DATA_W-1:0] v);
        return signed'({{(MOP_W-DATA_W){v[DATA_W-1]}}, v});
    endfunction

    function automatic logic [DATA_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
        if (v > SAT_MAX) begin
            return SAT_MAX[DATA_W-1:0];
        end else if (v < SAT_MIN) begin
            return SAT_MIN[DATA_W-1:0];
        end
        return v[DATA_W-1:0];
    endfunction

    logic [1:0]               r_mode;
    logic [CNT_W-1:0]         r_kcnt;
    logic [DATA_W-1:0]        r_q;
    logic [KEY_W-1:0]         r_idx;
    logic [KEY_W-1:0]         r_cidx;
    logic [KEY_W-1:0]         r_b;
    logic [DATA_W-1:0]        r_tb;
    logic [DIV_W-1:0]         r_rem;
    logic [DIV_W-2:0]         r_dt;
    logic [FRAC_BITS-1:0]     r_quo;
    logic [DATA_W-1:0]        r_p0 [3];
    logic [DATA_W-1:0]        r_m0 [3];
    logic [DATA_W-1:0]        r_p1 [3];
    logic [DATA_W-1:0]        r_m1 [3];
    logic signed [MOP_W-1:0]  r_u2, r_u3, r_s10, r_s11;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  r_acc [3];
    t_out                     r_res;

    logic [CNT_W-1:0]   n_keys;
    logic [CNT_W-1:0]   n_m1;
    logic [KEY_W-1:0]   last_key;
    logic [KEY_W-1:0]   key_a;
    logic [KEY_W-1:0]   t_raddr;
    logic [KEY_W-1:0]   c_key;
    logic [CADDR_W-1:0] c_raddr;
    logic [CADDR_W-1:0] c_waddr;
    logic               c_we;
    logic [DATA_W-1:0]  t_rd;
    logic [DATA_W-1:0]  c_rd [3];
    logic [DATA_W-1:0]  c_wd [3];

    assign n_keys   = (r_kcnt > CNT_W'(MAX_KEYS)) ? CNT_W'(MAX_KEYS) : r_kcnt;
    assign n_m1     = n_keys - CNT_W'(1);
    assign last_key = n_m1[KEY_W-1:0];
    assign key_a    = r_b - KEY_W'(1);

    always_comb begin
        case (i_cmd.taddr_sel)
            TA_FIRST: t_raddr = '0;
            TA_LAST:  t_raddr = last_key;
            TA_SCAN:  t_raddr = r_idx;
            TA_PREV:  t_raddr = key_a;
            default:  t_raddr = '0;
        endcase
        case (i_cmd.ckey)
            CK_FIRST: c_key = '0;
            CK_LAST:  c_key = last_key;
            CK_A:     c_key = key_a;
            CK_B:     c_key = r_b;
            default:  c_key = '0;
        endcase
    end

    assign c_raddr = comp_addr(c_key, i_cmd.cslot);
    assign c_waddr = comp_addr(i_in.key_index, i_in.slot);
    assign c_we    = i_cmd.load_we;
    assign c_wd[0] = i_in.vec_x;
    assign c_wd[1] = i_in.vec_y;
    assign c_wd[2] = i_in.vec_z;

    kfvs_ram #(.W(DATA_W), .D(MAX_KEYS)) u_time_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.load_we),
        .i_waddr (i_in.key_index),
        .i_wdata (i_in.time_value),
        .i_raddr (t_raddr),
        .o_rdata (t_rd)
    );

    for (genvar g = 0; g < 3; g++) begin : g_comp
        kfvs_ram #(.W(DATA_W), .D(CDEPTH)) u_comp_ram (
            .i_clk   (i_clk),
            .i_we    (c_we),
            .i_waddr (c_waddr),
            .i_wdata (c_wd[g]),
            .i_raddr (c_raddr),
            .o_rdata (c_rd[g])
        );
    end

    // interval setup and restoring divider
    logic [DATA_W:0]  diff33, dt33, dt_pos;
    logic [DIV_W-1:0] rem2, dtx;

    assign diff33 = {r_q[DATA_W-1], r_q} - {t_rd[DATA_W-1], t_rd};
    assign dt33   = {r_tb[DATA_W-1], r_tb} - {t_rd[DATA_W-1], t_rd};
    assign dt_pos = (!dt33[DATA_W] && (dt33 != '0)) ? dt33 : (DATA_W+1)'(1);
    assign rem2   = {r_rem[DIV_W-2:0], 1'b0};
    assign dtx    = {1'b0, r_dt};

    // Hermite basis from u, u^2, u^3
    logic signed [MOP_W-1:0] u_s, dt_s, h00, h10, h01, h11, op_a, op_b, lin_d;
    logic signed [PROD_W-1:0] prod, prod_sh;
    logic signed [ACC_W-1:0]  term;

    assign u_s  = signed'({{(MOP_W-FRAC_BITS){1'b0}}, r_quo});
    assign dt_s = signed'({{(MOP_W-DIV_W+1){1'b0}}, r_dt});
    assign h00  = (r_u3 <<< 1) - ((r_u2 <<< 1) + r_u2) + ONE;
    assign h10  = r_u3 - (r_u2 <<< 1) + u_s;
    assign h01  = ((r_u2 <<< 1) + r_u2) - (r_u3 <<< 1);
    assign h11  = r_u3 - r_u2;
    assign lin_d = sx(r_p1[i_cmd.comp]) - sx(r_p0[i_cmd.comp]);

    always_comb begin
        case (i_cmd.mop)
            MO_UU:    begin op_a = u_s;   op_b = u_s;                   end
            MO_U2U:   begin op_a = r_u2;  op_b = u_s;                   end
            MO_H10DT: begin op_a = h10;   op_b = dt_s;                  end
            MO_H11DT: begin op_a = h11;   op_b = dt_s;                  end
            MO_LIN:   begin op_a = lin_d; op_b = u_s;                   end
            MO_H00P0: begin op_a = h00;   op_b = sx(r_p0[i_cmd.comp]);  end
            MO_S10M0: begin op_a = r_s10; op_b = sx(r_m0[i_cmd.comp]);  end
            MO_H01P1: begin op_a = h01;   op_b = sx(r_p1[i_cmd.comp]);  end
            MO_S11M1: begin op_a = r_s11; op_b = sx(r_m1[i_cmd.comp]);  end
            default:  begin op_a = '0;    op_b = '0;                    end
        endcase
    end

    assign prod    = op_a * op_b;
    assign prod_sh = r_prod >>> FRAC_BITS;
    assign term    = prod_sh[ACC_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_LINEAR;
            r_kcnt <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_INTERP_MODE: r_mode <= i_cfg_data[1:0];
                REG_KEY_COUNT:   r_kcnt <= i_cfg_data[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_cidx <= r_idx;
        if (i_cmd.sample_start) begin
            r_q <= i_in.time_value;
        end
        if (i_cmd.idx_init) begin
            r_idx <= KEY_W'(1);
        end else if (i_cmd.idx_inc) begin
            r_idx <= r_idx + KEY_W'(1);
        end
        if (i_cmd.latch_b) begin
            r_b  <= r_cidx;
            r_tb <= t_rd;
        end
        if (i_cmd.dt_load) begin
            r_rem <= {1'b0, diff33};
            r_dt  <= dt_pos;
        end else if (i_cmd.div_step) begin
            if (rem2 >= dtx) begin
                r_rem <= rem2 - dtx;
                r_quo <= {r_quo[FRAC_BITS-2:0], 1'b1};
            end else begin
                r_rem <= rem2;
                r_quo <= {r_quo[FRAC_BITS-2:0], 1'b0};
            end
        end
        for (int k = 0; k < 3; k++) begin
            if (i_cmd.cap_en) begin
                case (i_cmd.cap_sel)
                    CAP_P0:  r_p0[k] <= c_rd[k];
                    CAP_M0:  r_m0[k] <= c_rd[k];
                    CAP_P1:  r_p1[k] <= c_rd[k];
                    CAP_M1:  r_m1[k] <= c_rd[k];
                    default: ;
                endcase
            end
            if (i_cmd.acc_init) begin
                r_acc[k] <= i_cmd.acc_lin ?
                    signed'({{(ACC_W-DATA_W){r_p0[k][DATA_W-1]}}, r_p0[k]}) : '0;
            end
        end
        if (i_cmd.mul_issue) begin
            r_prod <= prod;
        end
        if (i_cmd.mul_cap) begin
            case (i_cmd.mop)
                MO_UU:    r_u2  <= prod_sh[MOP_W-1:0];
                MO_U2U:   r_u3  <= prod_sh[MOP_W-1:0];
                MO_H10DT: r_s10 <= prod_sh[MOP_W-1:0];
                MO_H11DT: r_s11 <= prod_sh[MOP_W-1:0];
                default:  r_acc[i_cmd.comp] <= r_acc[i_cmd.comp] + term;
            endcase
        end
        if (i_cmd.res_load) begin
            case (i_cmd.res_sel)
                RS_EMPTY: r_res <= '{out_x: '0, out_y: '0, out_z: '0, was_empty: 1'b1};
                RS_VALUE: r_res <= '{out_x: r_p0[0], out_y: r_p0[1], out_z: r_p0[2],
                                     was_empty: 1'b0};
                RS_ACC:   r_res <= '{out_x: sat32(r_acc[0]), out_y: sat32(r_acc[1]),
                                     out_z: sat32(r_acc[2]), was_empty: 1'b0};
                default:  r_res <= '{out_x: '0, out_y: '0, out_z: '0, was_empty: 1'b0};
            endcase
        end
    end

    assign o_stat.n_zero    = (r_kcnt == '0);
    assign o_stat.mode      = r_mode;
    assign o_stat.q_le_t    = $signed(r_q) <= $signed(t_rd);
    assign o_stat.q_ge_t    = $signed(r_q) >= $signed(t_rd);
    assign o_stat.t_gt_q    = $signed(t_rd) > $signed(r_q);
    assign o_stat.cidx_last = (r_cidx == last_key);
    assign o_out            = r_res;

endmodule
`default_nettype wire

// File: rtl/kfvs_ctrl.sv
`default_nettype none
module kfvs_ctrl
    import kfvs_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire logic       i_op,
    input  wire logic [1:0] i_slot,
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    input  wire t_stat      i_stat,
    output t_cmd            o_cmd
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_T0   = 4'd1;
    localparam logic [3:0] S_T0C  = 4'd2;
    localparam logic [3:0] S_TL   = 4'd3;
    localparam logic [3:0] S_TLC  = 4'd4;
    localparam logic [3:0] S_C0   = 4'd5;
    localparam logic [3:0] S_CL   = 4'd6;
    localparam logic [3:0] S_CCAP = 4'd7;
    localparam logic [3:0] S_SRCH = 4'd8;
    localparam logic [3:0] S_TA   = 4'd9;
    localparam logic [3:0] S_DT   = 4'd10;
    localparam logic [3:0] S_DIV  = 4'd11;
    localparam logic [3:0] S_RV   = 4'd12;
    localparam logic [3:0] S_MUL  = 4'd13;
    localparam logic [3:0] S_DONE = 4'd14;

    localparam logic [3:0] DIV_LAST   = 4'(FRAC_BITS - 1);
    localparam logic [3:0] RV_LAST    = 4'd4;
    localparam logic [3:0] LIN_LAST   = 4'd2;
    localparam logic [3:0] CUBIC_LAST = 4'd15;
    localparam logic [3:0] CUBIC_VEC  = 4'd4;

    logic [3:0] r_state, n_state;
    logic       r_first, n_first;
    logic [3:0] r_cnt, n_cnt;
    logic [3:0] r_step, n_step;
    logic       r_ph, n_ph;
    logic [1:0] r_rsel, n_rsel;
    logic       r_ovalid, n_ovalid;

    logic       cubic;
    logic [3:0] step_off;
    logic [3:0] step_last;

    assign cubic     = (i_stat.mode == MODE_CUBIC);
    assign step_off  = r_step - CUBIC_VEC;
    assign step_last = cubic ? CUBIC_LAST : LIN_LAST;

    always_comb begin
        n_state  = r_state;
        n_first  = r_first;
        n_cnt    = r_cnt;
        n_step   = r_step;
        n_ph     = r_ph;
        n_rsel   = r_rsel;
        o_cmd    = '0;

        // multiply schedule: cubic, basis terms then four products per component; linear, one each
        if (cubic) begin
            if (r_step < CUBIC_VEC) begin
                case (r_step[1:0])
                    2'd0:    o_cmd.mop = MO_UU;
                    2'd1:    o_cmd.mop = MO_U2U;
                    2'd2:    o_cmd.mop = MO_H10DT;
                    default: o_cmd.mop = MO_H11DT;
                endcase
            end else begin
                o_cmd.comp = step_off[3:2];
                case (step_off[1:0])
                    2'd0:    o_cmd.mop = MO_H00P0;
                    2'd1:    o_cmd.mop = MO_S10M0;
                    2'd2:    o_cmd.mop = MO_H01P1;
                    default: o_cmd.mop = MO_S11M1;
                endcase
            end
        end else begin
            o_cmd.mop  = MO_LIN;
            o_cmd.comp = r_step[1:0];
        end

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_op == OP_LOAD) begin
                        o_cmd.load_we = (i_slot <= SLOT_OUT);
                    end else begin
                        o_cmd.sample_start = 1'b1;
                        if (i_stat.n_zero) begin
                            n_rsel  = RS_EMPTY;
                            n_state = S_DONE;
                        end else begin
                            n_state = S_T0;
                        end
                    end
                end
            end
            S_T0: begin
                o_cmd.taddr_sel = TA_FIRST;
                n_state = S_T0C;
            end
            S_T0C: begin
                n_state = i_stat.q_le_t ? S_C0 : S_TL;
            end
            S_TL: begin
                o_cmd.taddr_sel = TA_LAST;
                n_state = S_TLC;
            end
            S_TLC: begin
                if (i_stat.q_ge_t) begin
                    n_state = S_CL;
                end else begin
                    o_cmd.idx_init = 1'b1;
                    n_first = 1'b1;
                    n_state = S_SRCH;
                end
            end
            S_C0: begin
                o_cmd.ckey  = CK_FIRST;
                o_cmd.cslot = SLOT_VAL;
                n_state = S_CCAP;
            end
            S_CL: begin
                o_cmd.ckey  = CK_LAST;
                o_cmd.cslot = SLOT_VAL;
                n_state = S_CCAP;
            end
            S_CCAP: begin
                o_cmd.cap_en  = 1'b1;
                o_cmd.cap_sel = CAP_P0;
                n_rsel  = RS_VALUE;
                n_state = S_DONE;
            end
            S_SRCH: begin
                // one key time per cycle; the key time read is registered and r_cidx follows its address
                o_cmd.taddr_sel = TA_SCAN;
                o_cmd.idx_inc   = 1'b1;
                n_first = 1'b0;
                if (!r_first && (i_stat.t_gt_q || i_stat.cidx_last)) begin
                    o_cmd.latch_b = 1'b1;
                    n_state = S_TA;
                end
            end
            S_TA: begin
                o_cmd.taddr_sel = TA_PREV;
                n_state = S_DT;
            end
            S_DT: begin
                o_cmd.dt_load = 1'b1;
                n_cnt   = '0;
                n_state = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt = r_cnt + 4'd1;
                if (r_cnt == DIV_LAST) begin
                    n_cnt   = '0;
                    n_state = S_RV;
                end
            end
            S_RV: begin
                case (r_cnt)
                    4'd0:    begin o_cmd.ckey = CK_A; o_cmd.cslot = SLOT_VAL; end
                    4'd1:    begin o_cmd.ckey = CK_A; o_cmd.cslot = SLOT_OUT; end
                    4'd2:    begin o_cmd.ckey = CK_B; o_cmd.cslot = SLOT_VAL; end
                    default: begin o_cmd.ckey = CK_B; o_cmd.cslot = SLOT_IN;  end
                endcase
                case (r_cnt)
                    4'd1:    begin o_cmd.cap_en = 1'b1; o_cmd.cap_sel = CAP_P0; end
                    4'd2:    begin o_cmd.cap_en = 1'b1; o_cmd.cap_sel = CAP_M0; end
                    4'd3:    begin o_cmd.cap_en = 1'b1; o_cmd.cap_sel = CAP_P1; end
                    4'd4:    begin o_cmd.cap_en = 1'b1; o_cmd.cap_sel = CAP_M1; end
                    default: ;
                endcase
                n_cnt = r_cnt + 4'd1;
                if (r_cnt == RV_LAST) begin
                    n_cnt = '0;
                    case (i_stat.mode)
                        MODE_STEP: begin
                            n_rsel  = RS_VALUE;
                            n_state = S_DONE;
                        end
                        MODE_LINEAR, MODE_CUBIC: begin
                            o_cmd.acc_init = 1'b1;
                            o_cmd.acc_lin  = (i_stat.mode == MODE_LINEAR);
                            n_step  = '0;
                            n_ph    = 1'b0;
                            n_state = S_MUL;
                        end
                        default: begin
                            n_rsel  = RS_ZERO;
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_MUL: begin
                if (!r_ph) begin
                    o_cmd.mul_issue = 1'b1;
                    n_ph = 1'b1;
                end else begin
                    o_cmd.mul_cap = 1'b1;
                    n_ph   = 1'b0;
                    n_step = r_step + 4'd1;
                    if (r_step == step_last) begin
                        n_rsel  = RS_ACC;
                        n_state = S_DONE;
                    end
                end
            end
            S_DONE: begin
                if (!r_ovalid || i_out_ready) begin
                    o_cmd.res_load = 1'b1;
                    o_cmd.res_sel  = r_rsel;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        n_ovalid = r_ovalid;
        if (r_ovalid && i_out_ready) begin
            n_ovalid = 1'b0;
        end
        if (o_cmd.res_load) begin
            n_ovalid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_first  <= 1'b0;
            r_cnt    <= '0;
            r_step   <= '0;
            r_ph     <= 1'b0;
            r_rsel   <= RS_ZERO;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_first  <= n_first;
            r_cnt    <= n_cnt;
            r_step   <= n_step;
            r_ph     <= n_ph;
            r_rsel   <= n_rsel;
            r_ovalid <= n_ovalid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_ovalid;

endmodule
`default_nettype wire

// File: rtl/keyframe_vector_sampler_unit.sv
`default_nettype none
// Channel   Direction  Handshake                   Payload
// in        input      i_in_valid / o_in_ready     i_in  (t_in)
// out       output     o_out_valid / i_out_ready   o_out (t_out)
// cfg       input      i_cfg_valid / o_cfg_ready   i_cfg_index, i_cfg_data
//
// A sample of an empty table returns zero with was_empty set; a time at or before the
// first key or at or after the last key returns that key's value. For an interior time
// the key time scan reads one entry per cycle up to the bracketing key, and in linear
// and cubic modes the shared 36x36 multiplier registers each product before it is
// accumulated.
// A new item is taken while the last result still waits in the output register.
// Synchronous active-low reset; key memories are not cleared.
module keyframe_vector_sampler_unit
    import kfvs_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire t_in                   i_in,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output t_out                       o_out,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cmd  cmd;
    t_stat stat;

    assign o_cfg_ready = 1'b1;

    kfvs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_op        (i_in.op),
        .i_slot      (i_in.slot),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    kfvs_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_in        (i_in),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_out       (o_out)
    );

endmodule
`default_nettype wire
